FILE: src/dwtq_pkg.sv
`timescale 1ns / 1ps
package dwtq_pkg;

    localparam int SLOT_COUNT  = 16;
    localparam int QUEUE_DEPTH = 16;
    localparam int SLOT_W      = 4;
    localparam int QW          = $clog2(QUEUE_DEPTH);
    localparam int CW          = QW + 1;

    localparam logic [23:0] IDLE_WAKE = 24'd10000000;
    localparam logic [47:0] TOTAL_MAX = 48'hFFFF_FFFF_FFFF;
    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

    localparam logic [1:0] K_CREATE   = 2'd0;
    localparam logic [1:0] K_DESTROY  = 2'd1;
    localparam logic [1:0] K_SCHEDULE = 2'd2;
    localparam logic [1:0] K_SCAN     = 2'd3;

    localparam logic [2:0] R_CREATED   = 3'd0;
    localparam logic [2:0] R_DESTROYED = 3'd1;
    localparam logic [2:0] R_SCHEDULED = 3'd2;
    localparam logic [2:0] R_FIRED     = 3'd3;
    localparam logic [2:0] R_SCAN_DONE = 3'd4;

    typedef struct packed {
        logic [31:0] min_iv;
        logic [31:0] max_iv;
        logic [47:0] total;
        logic [31:0] count;
    } t_stats;

    typedef struct packed {
        logic [2:0]        kind;
        logic              ok;
        logic [SLOT_W-1:0] slot;
        logic [31:0]       iv;
        t_stats            st;
        logic [23:0]       wake;
        logic              last;
    } t_result;

endpackage

FILE: src/dwtq_stats.sv
`timescale 1ns / 1ps
// Interval statistics update for one fire: min, max, saturating total and count.
module dwtq_stats (
    input  dwtq_pkg::t_stats i_cur,
    input  logic [31:0]      i_iv,
    output dwtq_pkg::t_stats o_new
);
    logic [48:0] sum;

    assign sum = {1'b0, i_cur.total} + {17'b0, i_iv};

    always_comb begin
        o_new.min_iv = (i_iv < i_cur.min_iv) ? i_iv : i_cur.min_iv;
        o_new.max_iv = (i_iv > i_cur.max_iv) ? i_iv : i_cur.max_iv;
        o_new.total  = sum[48] ? dwtq_pkg::TOTAL_MAX : sum[47:0];
        o_new.count  = (i_cur.count == dwtq_pkg::COUNT_MAX) ? i_cur.count
                                                            : i_cur.count + 32'd1;
    end
endmodule

FILE: src/delayed_work_timer_queue_core.sv
`timescale 1ns / 1ps
// Channel   Dir  tdata (low bit up)                                tuser        tlast
// s_axis    in   handle[3:0] delay[35:4] now[67:36], pad to 72     kind[1:0]    -
// m_axis    out  ok[0] slot[4:1] interval[36:5] min_interval[68:37] result_kind  last
//                max_interval[100:69] interval_total[148:101]
//                fire_count[180:149] next_wake[204:181], pad to 208
//
// Create, destroy and schedule pass through ST_EXEC, which waits for the output register.
// A scan runs ST_RD, ST_EL, ST_CMP per pending entry and ST_IV, ST_FIRE, ST_EMIT per fire;
// shared 33-bit subtractor computes elapsed time, expiry/remaining and interval in turn.
// o_s_axis_tready is high only in idle; a stalled output register holds the sequencer.
// Reset (i_rst_n low, synchronous) empties the slot table and the pending list.
module delayed_work_timer_queue_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_axis_tvalid,
    output logic           o_s_axis_tready,
    input  logic [71:0]    i_s_axis_tdata,   // handle, delay, now
    input  logic [1:0]     i_s_axis_tuser,   // kind
    output logic           o_m_axis_tvalid,
    input  logic           i_m_axis_tready,
    output logic [207:0]   o_m_axis_tdata,   // ok, slot, interval, min, max, total, count, wake
    output logic [2:0]     o_m_axis_tuser,   // result_kind
    output logic           o_m_axis_tlast
);
    typedef enum logic [3:0] {
        ST_IDLE, ST_EXEC, ST_RD, ST_EL, ST_CMP, ST_IV, ST_FIRE, ST_EMIT, ST_END
    } t_state;

    localparam int SC = dwtq_pkg::SLOT_COUNT;
    localparam int QD = dwtq_pkg::QUEUE_DEPTH;
    localparam int SW = dwtq_pkg::SLOT_W;
    localparam int QW = dwtq_pkg::QW;
    localparam int CW = dwtq_pkg::CW;

    t_state r_state;

    // slot table
    logic            r_valid [SC];
    logic [31:0]     r_delay [SC];
    logic [31:0]     r_qat   [SC];
    logic [31:0]     r_lft   [SC];
    logic            r_hf    [SC];
    dwtq_pkg::t_stats r_stat [SC];
    logic [SW-1:0]   r_list  [QD];
    logic [CW-1:0]   r_cnt;

    // latched beat
    logic [1:0]      r_kind;
    logic [SW-1:0]   r_h;
    logic [31:0]     r_din;
    logic [31:0]     r_now;

    // scan working set
    logic [CW-1:0]   r_idx;
    logic [CW-1:0]   r_w;
    logic [23:0]     r_next;
    logic [SW-1:0]   r_s;
    logic            r_sv;
    logic [31:0]     r_sdelay;
    logic [31:0]     r_sqat;
    logic [31:0]     r_slft;
    logic            r_shf;
    dwtq_pkg::t_stats r_st;
    logic [31:0]     r_el;
    logic [31:0]     r_iv;

    logic              r_out_valid;
    dwtq_pkg::t_result r_out;
    dwtq_pkg::t_result n_out;

    logic            out_free;
    logic            out_load;
    logic            good;
    logic            sched_ok;
    logic            free_any;
    logic [SW-1:0]   free_idx;
    logic [31:0]     sub_a, sub_b;
    logic [32:0]     sub;
    logic            expired;
    dwtq_pkg::t_stats st_new;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign out_free        = !r_out_valid || i_m_axis_tready;
    assign out_load        = out_free && (r_state == ST_EXEC || r_state == ST_EMIT ||
                                          r_state == ST_END);
    assign good            = ({1'b0, r_h} < (SW+1)'(SC)) && r_valid[r_h];
    assign sched_ok        = good && (r_cnt < CW'(QD));

    always_comb begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = SC - 1; i >= 0; i--) begin
            if (!r_valid[i]) begin
                free_any = 1'b1;
                free_idx = SW'(i);
            end
        end
    end

    // shared subtractor
    always_comb begin
        case (r_state)
            ST_CMP: begin
                sub_a = r_sdelay;
                sub_b = r_el;
            end
            ST_IV: begin
                sub_a = r_now;
                sub_b = r_slft;
            end
            default: begin
                sub_a = r_now;
                sub_b = r_sqat;
            end
        endcase
    end
    assign sub     = {1'b0, sub_a} - {1'b0, sub_b};
    assign expired = sub[32] || (sub[31:0] == 32'd0);

    dwtq_stats u_stats (
        .i_cur (r_st),
        .i_iv  (r_iv),
        .o_new (st_new)
    );

    // result beat loaded into the output register
    always_comb begin
        n_out = '0;
        case (r_state)
            ST_EXEC: begin
                n_out.last = 1'b1;
                n_out.slot = r_h;
                case (r_kind)
                    dwtq_pkg::K_CREATE: begin
                        n_out.kind = dwtq_pkg::R_CREATED;
                        n_out.ok   = free_any;
                        n_out.slot = free_idx;
                    end
                    dwtq_pkg::K_DESTROY: begin
                        n_out.kind = dwtq_pkg::R_DESTROYED;
                        n_out.ok   = good;
                    end
                    default: begin
                        n_out.kind = dwtq_pkg::R_SCHEDULED;
                        n_out.ok   = sched_ok;
                    end
                endcase
            end
            ST_EMIT: begin
                n_out.kind = dwtq_pkg::R_FIRED;
                n_out.ok   = 1'b1;
                n_out.slot = r_s;
                n_out.iv   = r_iv;
                n_out.st   = r_st;
            end
            ST_END: begin
                n_out.kind = dwtq_pkg::R_SCAN_DONE;
                n_out.ok   = 1'b1;
                n_out.wake = r_next;
                n_out.last = 1'b1;
            end
            default: begin
                n_out = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
            r_out       <= '0;
            for (int i = 0; i < SC; i++) begin
                r_valid[i]       <= 1'b0;
                r_hf[i]          <= 1'b0;
                r_stat[i].min_iv <= '1;
                r_stat[i].max_iv <= '0;
                r_stat[i].total  <= '0;
                r_stat[i].count  <= '0;
            end
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
                r_out       <= n_out;
            end else if (r_out_valid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_s_axis_tvalid) begin
                        r_kind <= i_s_axis_tuser;
                        r_h    <= i_s_axis_tdata[3:0];
                        r_din  <= i_s_axis_tdata[35:4];
                        r_now  <= i_s_axis_tdata[67:36];
                        r_idx  <= '0;
                        r_w    <= '0;
                        r_next <= dwtq_pkg::IDLE_WAKE;
                        r_state <= (i_s_axis_tuser == dwtq_pkg::K_SCAN) ? ST_RD : ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    if (out_free) begin
                        case (r_kind)
                            dwtq_pkg::K_CREATE: begin
                                if (free_any) begin
                                    r_valid[free_idx]       <= 1'b1;
                                    r_delay[free_idx]       <= r_din;
                                    r_hf[free_idx]          <= 1'b0;
                                    r_stat[free_idx].min_iv <= '1;
                                    r_stat[free_idx].max_iv <= '0;
                                    r_stat[free_idx].total  <= '0;
                                    r_stat[free_idx].count  <= '0;
                                end
                            end
                            dwtq_pkg::K_DESTROY: begin
                                if (good) begin
                                    r_valid[r_h] <= 1'b0;
                                end
                            end
                            default: begin
                                if (sched_ok) begin
                                    r_list[r_cnt[QW-1:0]] <= r_h;
                                    r_cnt                 <= r_cnt + CW'(1);
                                    r_qat[r_h]            <= r_now;
                                end
                            end
                        endcase
                        r_state <= ST_IDLE;
                    end
                end
                ST_RD: begin
                    if (r_idx == r_cnt) begin
                        r_state <= ST_END;
                    end else begin
                        r_s      <= r_list[r_idx[QW-1:0]];
                        r_sv     <= r_valid[r_list[r_idx[QW-1:0]]];
                        r_sdelay <= r_delay[r_list[r_idx[QW-1:0]]];
                        r_sqat   <= r_qat[r_list[r_idx[QW-1:0]]];
                        r_slft   <= r_lft[r_list[r_idx[QW-1:0]]];
                        r_shf    <= r_hf[r_list[r_idx[QW-1:0]]];
                        r_st     <= r_stat[r_list[r_idx[QW-1:0]]];
                        r_state  <= ST_EL;
                    end
                end
                ST_EL: begin
                    r_el    <= sub[31:0];
                    r_state <= ST_CMP;
                end
                ST_CMP: begin
                    if (!r_sv) begin
                        // destroyed slot: entry dropped
                        r_idx   <= r_idx + CW'(1);
                        r_state <= ST_RD;
                    end else if (expired) begin
                        r_state <= ST_IV;
                    end else begin
                        if (sub[31:0] < {8'b0, r_next}) begin
                            r_next <= sub[23:0];
                        end
                        r_list[r_w[QW-1:0]] <= r_s;
                        r_w     <= r_w + CW'(1);
                        r_idx   <= r_idx + CW'(1);
                        r_state <= ST_RD;
                    end
                end
                ST_IV: begin
                    r_iv    <= r_shf ? sub[31:0] : r_el;
                    r_state <= ST_FIRE;
                end
                ST_FIRE: begin
                    r_stat[r_s] <= st_new;
                    r_lft[r_s]  <= r_now;
                    r_hf[r_s]   <= 1'b1;
                    r_st        <= st_new;
                    r_state     <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (out_free) begin
                        r_idx   <= r_idx + CW'(1);
                        r_state <= ST_RD;
                    end
                end
                ST_END: begin
                    if (out_free) begin
                        r_cnt   <= r_w;
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out.kind;
    assign o_m_axis_tlast  = r_out.last;
    assign o_m_axis_tdata  = {3'b0, r_out.wake, r_out.st.count, r_out.st.total,
                              r_out.st.max_iv, r_out.st.min_iv, r_out.iv,
                              r_out.slot, r_out.ok};
endmodule

FILE: dv/testbench.sv
`timescale 1ns / 1ps
module testbench;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_axis_tvalid = 1'b0;
    logic         o_s_axis_tready;
    logic [71:0]  i_s_axis_tdata = '0;    // handle, delay, now
    logic [1:0]   i_s_axis_tuser = '0;    // kind
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready = 1'b0;
    logic [207:0] o_m_axis_tdata;         // ok, slot, interval, min, max, total, count, wake
    logic [2:0]   o_m_axis_tuser;         // result_kind
    logic         o_m_axis_tlast;

    delayed_work_timer_queue_core dut (.*);

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Expected result beat, kept in the port's own layout.
    typedef struct {
        logic [2:0]   kind;
        logic [207:0] data;
        logic         last;
    } t_beat;

    t_beat timer_results[$];

    // Shadow copy of the slot table and the pending list.
    logic        sh_valid[dwtq_pkg::SLOT_COUNT];
    logic [31:0] sh_delay[dwtq_pkg::SLOT_COUNT];
    logic [31:0] sh_queued[dwtq_pkg::SLOT_COUNT];
    logic [31:0] sh_last_fire[dwtq_pkg::SLOT_COUNT];
    logic        sh_fired[dwtq_pkg::SLOT_COUNT];
    logic [31:0] sh_min[dwtq_pkg::SLOT_COUNT];
    logic [31:0] sh_max[dwtq_pkg::SLOT_COUNT];
    logic [47:0] sh_total[dwtq_pkg::SLOT_COUNT];
    logic [31:0] sh_count[dwtq_pkg::SLOT_COUNT];
    logic [3:0]  sh_pending[$];

    int  errors = 0;
    int  fires_seen = 0;
    int  beats_seen = 0;
    int  cycles = 0;
    bit  drain = 0;      // last part of the run: no idling
    int  hold_off = 0;   // long receiver stall, in cycles
    int  rx_idle = 0;    // remaining cycles of a short receiver stall
    logic [31:0] clock_us = 0;

    function automatic t_beat make_beat(logic [2:0] k, logic ok, logic [3:0] s);
        t_beat b;
        b.kind = k;
        b.data = '0;
        b.data[0] = ok;
        b.data[4:1] = s;
        b.last = 1'b1;
        return b;
    endfunction

    function automatic void add_expected(t_beat b);
        timer_results = {timer_results, b};
    endfunction

    // Works out the results of one accepted item and updates the shadow state.
    task automatic predict_timer_op(logic [1:0] k, logic [3:0] h, logic [31:0] dly,
                                    logic [31:0] now);
        logic [3:0]  keep[$];
        logic [31:0] wake, el, iv, rem;
        logic [48:0] sum;
        t_beat b;
        bit found;
        found = 0;
        case (k)
            dwtq_pkg::K_CREATE: begin
                for (int i = 0; i < dwtq_pkg::SLOT_COUNT; i++)
                    if (!found && !sh_valid[i]) begin
                        found = 1;
                        sh_valid[i] = 1; sh_delay[i] = dly; sh_fired[i] = 0;
                        sh_last_fire[i] = 0; sh_min[i] = '1; sh_max[i] = 0;
                        sh_total[i] = 0; sh_count[i] = 0;
                        add_expected(make_beat(dwtq_pkg::R_CREATED, 1'b1, i[3:0]));
                    end
                if (!found) add_expected(make_beat(dwtq_pkg::R_CREATED, 1'b0, 4'd0));
            end
            dwtq_pkg::K_DESTROY: begin
                add_expected(make_beat(dwtq_pkg::R_DESTROYED, sh_valid[h], h));
                sh_valid[h] = 0;
            end
            dwtq_pkg::K_SCHEDULE: begin
                if (sh_valid[h] && sh_pending.size() < dwtq_pkg::QUEUE_DEPTH) begin
                    sh_pending = {sh_pending, h};
                    sh_queued[h] = now;
                    add_expected(make_beat(dwtq_pkg::R_SCHEDULED, 1'b1, h));
                end else
                    add_expected(make_beat(dwtq_pkg::R_SCHEDULED, 1'b0, h));
            end
            default: begin
                wake = 32'd10000000;
                foreach (sh_pending[j]) begin
                    automatic logic [3:0] s = sh_pending[j];
                    if (sh_valid[s]) begin
                        el = now - sh_queued[s];
                        if (el >= sh_delay[s]) begin
                            iv = sh_fired[s] ? now - sh_last_fire[s] : el;
                            if (iv < sh_min[s]) sh_min[s] = iv;
                            if (iv > sh_max[s]) sh_max[s] = iv;
                            sum = sh_total[s] + iv;
                            sh_total[s] = sum[48] ? dwtq_pkg::TOTAL_MAX : sum[47:0];
                            if (sh_count[s] != dwtq_pkg::COUNT_MAX) sh_count[s]++;
                            sh_last_fire[s] = now;
                            sh_fired[s] = 1;
                            b = make_beat(dwtq_pkg::R_FIRED, 1'b1, s);
                            b.data[36:5] = iv;
                            b.data[68:37] = sh_min[s];
                            b.data[100:69] = sh_max[s];
                            b.data[148:101] = sh_total[s];
                            b.data[180:149] = sh_count[s];
                            b.last = 1'b0;
                            add_expected(b);
                        end else begin
                            rem = sh_delay[s] - el;
                            if (rem < wake) wake = rem;
                            keep = {keep, s};
                        end
                    end
                end
                sh_pending = keep;
                b = make_beat(dwtq_pkg::R_SCAN_DONE, 1'b1, 4'd0);
                b.data[204:181] = wake[23:0];
                add_expected(b);
            end
        endcase
    endtask

    task automatic report_mismatch(string what, logic [207:0] got, logic [207:0] want);
        errors++;
        $display("MISMATCH %s at beat %0d: got %h expected %h", what, beats_seen, got, want);
    endtask

    // Sends one item; inputs change on the falling edge, accept on a rising edge.
    task automatic send_op(logic [1:0] k, logic [3:0] h, logic [31:0] dly,
                           logic [31:0] now, bit gaps = 1);
        @(negedge i_clk);
        if (gaps && !drain && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 8)) @(negedge i_clk);
        i_s_axis_tdata <= {4'b0, now, dly, h};
        i_s_axis_tuser <= k;
        i_s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!o_s_axis_tready);
        predict_timer_op(k, h, dly, now);
        @(negedge i_clk);
        i_s_axis_tvalid <= 1'b0;
    endtask

    task automatic wait_results_empty();
        while (timer_results.size() != 0) @(negedge i_clk);
        repeat (100) @(negedge i_clk);
    endtask

    // Receiver side: short random stall bursts, plus the long hold-off.
    always @(negedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            i_m_axis_tready <= 1'b0;
        end else if (rx_idle > 0) begin
            rx_idle <= rx_idle - 1;
            i_m_axis_tready <= 1'b0;
        end else if (!drain && $urandom_range(0, 5) == 0) begin
            rx_idle <= $urandom_range(0, 7);
            i_m_axis_tready <= 1'b0;
        end else
            i_m_axis_tready <= 1'b1;
    end

    always @(posedge i_clk) begin
        t_beat e;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            beats_seen++;
            if (timer_results.size() == 0)
                report_mismatch("unexpected beat", o_m_axis_tdata, '0);
            else begin
                e = timer_results.pop_front();
                if (o_m_axis_tuser == dwtq_pkg::R_FIRED) fires_seen++;
                if (o_m_axis_tuser !== e.kind)
                    report_mismatch("result_kind", o_m_axis_tuser, e.kind);
                if (o_m_axis_tlast !== e.last)
                    report_mismatch("last", o_m_axis_tlast, e.last);
                if (o_m_axis_tdata[0] !== e.data[0])
                    report_mismatch("ok", o_m_axis_tdata[0], e.data[0]);
                if (o_m_axis_tdata[4:1] !== e.data[4:1])
                    report_mismatch("slot", o_m_axis_tdata[4:1], e.data[4:1]);
                if (o_m_axis_tdata[36:5] !== e.data[36:5])
                    report_mismatch("interval", o_m_axis_tdata[36:5], e.data[36:5]);
                if (o_m_axis_tdata[68:37] !== e.data[68:37])
                    report_mismatch("min_interval", o_m_axis_tdata[68:37], e.data[68:37]);
                if (o_m_axis_tdata[100:69] !== e.data[100:69])
                    report_mismatch("max_interval", o_m_axis_tdata[100:69],
                                    e.data[100:69]);
                if (o_m_axis_tdata[148:101] !== e.data[148:101])
                    report_mismatch("interval_total", o_m_axis_tdata[148:101],
                                    e.data[148:101]);
                if (o_m_axis_tdata[180:149] !== e.data[180:149])
                    report_mismatch("fire_count", o_m_axis_tdata[180:149],
                                    e.data[180:149]);
                if (o_m_axis_tdata[207:181] !== e.data[207:181])
                    report_mismatch("next_wake", o_m_axis_tdata[207:181],
                                    e.data[207:181]);
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > 400000) begin
            $display("Timeout after %0d cycles", cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Directed: field extremes, every kind, refusals, wrap, dangling entries.
    task automatic test_directed();
        send_op(dwtq_pkg::K_SCAN, 4'd0, 32'd0, 32'd0);                 // empty scan
        send_op(dwtq_pkg::K_DESTROY, 4'd15, 32'hFFFF_FFFF, 32'd0);      // bad slot
        send_op(dwtq_pkg::K_SCHEDULE, 4'd3, 32'd0, 32'hFFFF_FFFF);      // bad slot
        send_op(dwtq_pkg::K_CREATE, 4'd15, 32'd0, 32'hFFFF_FFFF);       // slot 0, delay 0
        send_op(dwtq_pkg::K_CREATE, 4'd0, 32'hFFFF_FFFF, 32'd0);        // slot 1, max delay
        send_op(dwtq_pkg::K_CREATE, 4'd0, 32'd20000000, 32'd0);         // slot 2, wake caps
        send_op(dwtq_pkg::K_SCHEDULE, 4'd0, 32'd0, 32'hFFFF_FFF0);
        send_op(dwtq_pkg::K_SCHEDULE, 4'd1, 32'd0, 32'd5);
        send_op(dwtq_pkg::K_SCHEDULE, 4'd2, 32'd0, 32'd5);
        send_op(dwtq_pkg::K_SCHEDULE, 4'd0, 32'd0, 32'hFFFF_FFF8);      // repeat, wraps
        send_op(dwtq_pkg::K_SCAN, 4'd0, 32'd0, 32'd10);
        send_op(dwtq_pkg::K_DESTROY, 4'd1, 32'd0, 32'd0);               // dangling entry
        send_op(dwtq_pkg::K_CREATE, 4'd0, 32'd3, 32'd0);                // reuses slot 1
        send_op(dwtq_pkg::K_SCAN, 4'd0, 32'd0, 32'd9);
        send_op(dwtq_pkg::K_DESTROY, 4'd2, 32'd0, 32'd0);
        send_op(dwtq_pkg::K_SCAN, 4'd0, 32'd0, 32'hFFFF_FFFF);
        // Fill the table and the list to their limits.
        repeat (15) send_op(dwtq_pkg::K_CREATE, 4'd0, 32'd1, 32'd0);
        for (int i = 0; i < 17; i++) send_op(dwtq_pkg::K_SCHEDULE, i[3:0], 32'd0, 32'd100);
        send_op(dwtq_pkg::K_SCAN, 4'd0, 32'd0, 32'd100);
        send_op(dwtq_pkg::K_SCAN, 4'd0, 32'd0, 32'd101);
        wait_results_empty();
    endtask

    // Long receiver stall while items keep coming: the block must back up.
    task automatic test_backpressure();
        hold_off = 400;
        for (int i = 0; i < 6; i++)
            send_op(dwtq_pkg::K_SCHEDULE, i[3:0], 32'd0, clock_us, 0);
        send_op(dwtq_pkg::K_SCAN, 4'd0, 32'd0, clock_us + 5, 0);
        wait_results_empty();
    endtask

    // Mostly well-formed create/destroy/schedule/scan traffic on a moving clock.
    task automatic test_random(int n);
        logic [1:0]  k;
        logic [31:0] dly;
        for (int i = 0; i < n; i++) begin
            clock_us += $urandom_range(0, 40);
            k = $urandom_range(0, 9) < 4 ? dwtq_pkg::K_SCHEDULE : 2'($urandom_range(0, 3));
            dly = $urandom_range(0, 7) == 0 ? $urandom : $urandom_range(0, 60);
            send_op(k, 4'($urandom_range(0, 15)), dly,
                    $urandom_range(0, 15) == 0 ? $urandom : clock_us);
        end
    endtask

    initial begin
        for (int i = 0; i < dwtq_pkg::SLOT_COUNT; i++) begin
            sh_valid[i] = 0; sh_fired[i] = 0; sh_min[i] = '1; sh_max[i] = 0;
            sh_total[i] = 0; sh_count[i] = 0; sh_delay[i] = 0; sh_queued[i] = 0;
            sh_last_fire[i] = 0;
        end
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_backpressure();
        test_random(50);
        wait_results_empty();   // sender pauses until all results are in
        drain = 1;
        test_random(15);
        wait_results_empty();
        $display("Covered all kinds, refusals, full table and list, wrapped time,");
        $display("%0d result beats including %0d fires", beats_seen, fires_seen);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end
endmodule
